FILE: rtl/core/multi_channel_debounce_reporter_core_defines.svh
// assertion macros shared by the debounce reporter rtl
`ifndef MULTI_CHANNEL_DEBOUNCE_REPORTER_CORE_DEFINES_SVH
`define MULTI_CHANNEL_DEBOUNCE_REPORTER_CORE_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define MCDR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define MCDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/mcdr_pkg.sv
// types and constants of the debounce reporter
`timescale 1ns / 1ps

package mcdr_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SAMP,
		ST_PUB,
		ST_FLUSH
	} state_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIODS_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIODS_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTV  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP_HOLD = 3'd6;
	localparam int unsigned CFG_DATA_W = 64;

	// reset values of the timing registers
	localparam logic [15:0] DEBOUNCE_RST = 16'd75;
	localparam logic [15:0] SAMPLE_INTV_RST = 16'd50;
	localparam logic [15:0] STARTUP_HOLD_RST = 16'd1000;

	// reported value code for a channel not reported yet
	localparam logic [1:0] REPORT_UNKNOWN = 2'd2;

	// re-report period: seconds to ms, 16-bit period times 1000 fits 26 bits
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned PERIOD_MS_W = 26;
	localparam logic [PERIOD_MS_W-1:0] MS_PER_SECOND = 26'd1000;

	// channels the reporting format can carry
	localparam int unsigned MAX_CH = 8;

endpackage

FILE: rtl/core/mcdr_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module mcdr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/multi_channel_debounce_reporter_core.sv
// top level of the multi-channel debounce reporter
`timescale 1ns / 1ps
`include "multi_channel_debounce_reporter_core_defines.svh"

// Debounce reporter for up to eight binary channels. Each item is either a
// time tick carrying the raw pin levels or a forced full report. A tick that
// falls inside the startup hold or the sample interval is dropped with no
// result. A sampling tick walks the channel state memory once to debounce and
// then walks the report memory once to decide reports, then drains the last
// report; a forced report skips the debounce walk. Each walk reads one entry
// of its state memory per cycle, and a stalled output pauses the report walk
// for as long as the stall lasts. A new item is taken only once the last one
// is through. Results leave through an output register, and the final result
// of an item carries last. State memories need no clearing after reset:
// per-entry valid bits stand in for the reset values.
module multi_channel_debounce_reporter_core
	import mcdr_pkg::*;
#(
	parameter int unsigned NUM_CHANNELS = 8,
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  logic [31:0]           now_ms,
	input  logic [7:0]            pin_levels,
	input  logic                  link_up,
	// output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            channel,
	output logic                  value,
	output logic [7:0]            debounced_mask,
	output logic                  last
);

	localparam int unsigned CH = (NUM_CHANNELS < MAX_CH) ? NUM_CHANNELS : MAX_CH;
	localparam int unsigned IW = (CH > 1) ? $clog2(CH) : 1;
	localparam int unsigned CNW = $clog2(CH + 1);
	localparam int unsigned TB = TIME_BITS;
	localparam int unsigned EW = (TB > PERIOD_MS_W) ? TB : PERIOD_MS_W;
	localparam int unsigned SW = TB + 1;
	localparam int unsigned RW = TB + 2;

	// configuration registers
	logic [3:0]            count_q;
	logic [7:0]            invert_q;
	logic [63:0]           per_lo_q;
	logic [63:0]           per_hi_q;
	logic [15:0]           debounce_q;
	logic [15:0]           intv_q;
	logic [15:0]           hold_ms_q;

	// sequencer and item registers
	state_t                state_q;
	state_t                state_d;
	logic                  func_q;
	logic [TB-1:0]         now_q;
	logic [7:0]            levels_q;
	logic                  link_q;
	logic [TB-1:0]         last_sample_q;
	logic [CH-1:0]         db_q;
	logic [CH-1:0]         samp_vld_q;
	logic [CH-1:0]         rep_vld_q;

	// walk pipeline
	logic [CNW-1:0]        rd_cnt_q;
	logic                  valid_s1;
	logic [IW-1:0]         idx_s1;

	// report held back until the next one or the end shows whether it is last
	logic                  hold_v_q;
	logic [IW-1:0]         hold_ch_q;
	logic                  hold_val_q;

	// output register
	logic                  out_valid_q;
	logic [2:0]            channel_q;
	logic                  value_q;
	logic [7:0]            mask_q;
	logic                  last_q;

	logic [CNW-1:0]        n_w;
	logic                  skip_w;
	logic [TB-1:0]         ls_el_w;
	logic                  out_free_w;
	logic                  pass_end_w;
	logic                  pass_start_w;
	logic                  rd_go_w;
	logic                  stall_w;
	logic                  push_hold_w;
	logic                  push_flush_w;

	// sample memory signals
	logic                  s_we_w;
	logic [SW-1:0]         s_wdata_w;
	logic [SW-1:0]         s_rdata;
	logic                  s_pend_w;
	logic [TB-1:0]         s_start_w;
	logic                  s_act_w;
	logic                  s_db_w;
	logic [TB-1:0]         s_el_w;
	logic                  s_pass_w;
	logic                  s_accept_w;

	// report memory signals
	logic                  r_we_w;
	logic [RW-1:0]         r_wdata_w;
	logic [RW-1:0]         r_rdata;
	logic [1:0]            r_rv_w;
	logic [1:0]            r_rv_eff_w;
	logic [TB-1:0]         r_at_w;
	logic                  r_v_w;
	logic [127:0]          per_all_w;
	logic [PERIOD_W-1:0]   r_per_w;
	logic [PERIOD_MS_W-1:0] r_per_ms_w;
	logic [TB-1:0]         r_el_w;
	logic                  r_outdated_w;
	logic                  r_report_w;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			invert_q <= '0;
			per_lo_q <= '0;
			per_hi_q <= '0;
			debounce_q <= DEBOUNCE_RST;
			intv_q <= SAMPLE_INTV_RST;
			hold_ms_q <= STARTUP_HOLD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SENSOR_COUNT: count_q <= cfg_data[3:0];
				REG_INVERT_MASK: invert_q <= cfg_data[7:0];
				REG_PERIODS_LOW: per_lo_q <= cfg_data;
				REG_PERIODS_HIGH: per_hi_q <= cfg_data;
				REG_DEBOUNCE: debounce_q <= cfg_data[15:0];
				REG_SAMPLE_INTV: intv_q <= cfg_data[15:0];
				REG_STARTUP_HOLD: hold_ms_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// channels in use, clipped to the channel limit
	assign n_w = (count_q > 4'(CH)) ? CNW'(CH) : CNW'(count_q);

	// tick gating: startup hold and sample interval
	assign ls_el_w = now_q - last_sample_q;
	assign skip_w = (now_q < TB'(hold_ms_q)) || !(ls_el_w > TB'(intv_q));

	assign out_free_w = !out_valid_q || out_ready;
	assign pass_end_w = (rd_cnt_q == n_w) && !valid_s1;
	assign pass_start_w = (state_q == ST_CHECK) || ((state_q == ST_SAMP) && pass_end_w);

	// debounce step for the channel in stage 1
	assign s_pend_w = samp_vld_q[idx_s1] ? s_rdata[TB] : 1'b0;
	assign s_start_w = samp_vld_q[idx_s1] ? s_rdata[TB-1:0] : '0;
	assign s_act_w = levels_q[idx_s1] ^ invert_q[idx_s1];
	assign s_db_w = db_q[idx_s1];
	assign s_el_w = now_q - s_start_w;
	assign s_pass_w = s_el_w > TB'(debounce_q);
	assign s_accept_w = (s_act_w != s_db_w) && s_pend_w && s_pass_w;
	assign s_we_w = (state_q == ST_SAMP) && valid_s1;

	always_comb begin
		if (s_act_w == s_db_w) begin
			s_wdata_w = '0;
		end else if (!s_pend_w) begin
			s_wdata_w = {1'b1, now_q};
		end else if (s_pass_w) begin
			s_wdata_w = '0;
		end else begin
			s_wdata_w = {1'b1, s_start_w};
		end
	end

	// report decision for the channel in stage 1
	assign r_rv_w = rep_vld_q[idx_s1] ? r_rdata[TB+1:TB] : REPORT_UNKNOWN;
	assign r_at_w = rep_vld_q[idx_s1] ? r_rdata[TB-1:0] : '0;
	assign r_rv_eff_w = (func_q || !link_q) ? REPORT_UNKNOWN : r_rv_w;
	assign r_v_w = db_q[idx_s1];
	assign per_all_w = {per_hi_q, per_lo_q};
	assign r_per_w = per_all_w[32'(idx_s1) * PERIOD_W +: PERIOD_W];
	assign r_per_ms_w = PERIOD_MS_W'(r_per_w) * MS_PER_SECOND;
	assign r_el_w = now_q - r_at_w;
	assign r_outdated_w = (r_per_w != '0) && r_v_w && (EW'(r_el_w) > EW'(r_per_ms_w));
	assign r_report_w = (state_q == ST_PUB) && valid_s1 && link_q
		&& (({1'b0, r_v_w} != r_rv_eff_w) || r_outdated_w);
	assign stall_w = r_report_w && hold_v_q && !out_free_w;
	assign r_we_w = (state_q == ST_PUB) && valid_s1 && !stall_w && (r_report_w || !link_q);
	assign r_wdata_w = link_q ? {1'b0, r_v_w, now_q} : {REPORT_UNKNOWN, r_at_w};

	// read issue: one entry a cycle, paused while a report waits for room
	assign rd_go_w = ((state_q == ST_SAMP) || (state_q == ST_PUB))
		&& (rd_cnt_q < n_w) && !stall_w && !pass_start_w;

	assign push_hold_w = r_report_w && hold_v_q && out_free_w;
	assign push_flush_w = (state_q == ST_FLUSH) && hold_v_q && out_free_w;

	mcdr_ram #(
		.WIDTH(SW),
		.DEPTH(CH)
	) u_samp_ram (
		.clk(clk),
		.we(s_we_w),
		.waddr(idx_s1),
		.wdata(s_wdata_w),
		.re(rd_go_w && (state_q == ST_SAMP)),
		.raddr(rd_cnt_q[IW-1:0]),
		.rdata(s_rdata)
	);

	mcdr_ram #(
		.WIDTH(RW),
		.DEPTH(CH)
	) u_rep_ram (
		.clk(clk),
		.we(r_we_w),
		.waddr(idx_s1),
		.wdata(r_wdata_w),
		.re(rd_go_w && (state_q == ST_PUB)),
		.raddr(rd_cnt_q[IW-1:0]),
		.rdata(r_rdata)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (func_q) begin
					state_d = ST_PUB;
				end else if (skip_w) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SAMP;
				end
			end
			ST_SAMP: begin
				if (pass_end_w) begin
					state_d = ST_PUB;
				end
			end
			ST_PUB: begin
				if (pass_end_w) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!hold_v_q || out_free_w) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q <= func;
			now_q <= TB'(now_ms);
			levels_q <= pin_levels;
			link_q <= link_up;
		end
	end

	// channel state kept in flip-flops: debounced bits, memory valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= '0;
			db_q <= '0;
			samp_vld_q <= '0;
			rep_vld_q <= '0;
		end else begin
			if ((state_q == ST_CHECK) && !func_q && !skip_w) begin
				last_sample_q <= now_q;
			end
			if (s_we_w) begin
				samp_vld_q[idx_s1] <= 1'b1;
				if (s_accept_w) begin
					db_q[idx_s1] <= s_act_w;
				end
			end
			if (r_we_w) begin
				rep_vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	// walk pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			valid_s1 <= 1'b0;
			idx_s1 <= '0;
		end else if (pass_start_w) begin
			rd_cnt_q <= '0;
			valid_s1 <= 1'b0;
		end else if (rd_go_w) begin
			rd_cnt_q <= rd_cnt_q + CNW'(1);
			valid_s1 <= 1'b1;
			idx_s1 <= rd_cnt_q[IW-1:0];
		end else if (!stall_w) begin
			valid_s1 <= 1'b0;
		end
	end

	// held report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			hold_ch_q <= '0;
			hold_val_q <= 1'b0;
		end else if (r_report_w && !stall_w) begin
			hold_v_q <= 1'b1;
			hold_ch_q <= idx_s1;
			hold_val_q <= r_v_w;
		end else if (push_flush_w) begin
			hold_v_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_hold_w || push_flush_w) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_hold_w || push_flush_w) begin
			channel_q <= 3'(hold_ch_q);
			value_q <= hold_val_q;
			mask_q <= 8'(db_q);
			last_q <= push_flush_w;
		end
	end

	assign out_valid = out_valid_q;
	assign channel = channel_q;
	assign value = value_q;
	assign debounced_mask = mask_q;
	assign last = last_q;

	// checks
	`MCDR_ASSERT_NOW(a_idle_no_hold, clk, arst_n, state_q == ST_IDLE, !hold_v_q,
		"report still held while idle")
	`MCDR_ASSERT_NOW(a_idx_in_range, clk, arst_n, valid_s1, CNW'(idx_s1) < n_w,
		"walk index beyond channels in use")
	`MCDR_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid_q && !out_ready,
		!(push_hold_w || push_flush_w), "output register overwritten")
	`MCDR_ASSERT_NEXT(a_check_leaves, clk, arst_n, state_q == ST_CHECK,
		state_q != ST_CHECK, "check state held more than one cycle")
	`MCDR_ASSERT_NOW(a_stall_pub_only, clk, arst_n, stall_w,
		(state_q == ST_PUB) && valid_s1, "stall outside the report walk")

endmodule

FILE: verif/multi_channel_debounce_reporter_core_test.sv
// testbench of the debounce reporter: bit-true scoreboard with random handshakes
`timescale 1ns / 1ps

module multi_channel_debounce_reporter_core_test;
	import mcdr_pkg::*;

	// item kinds on the func field
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_FORCE = 1'b1;

	localparam int NUM_REGS = 7;
	localparam int IDLE_PCT = 38;
	localparam int SETTLE_CYCLES = 64;

	typedef struct packed {
		logic [2:0] ch;
		logic       val;
		logic [7:0] mask;
		logic       lst;
	} report_t;

	// debounce and report predictor with the queue of expected reports
	class debounce_scoreboard;
		logic [3:0]  sensor_count;
		logic [7:0]  invert;
		logic [63:0] per_lo;
		logic [63:0] per_hi;
		logic [15:0] debounce;
		logic [15:0] sample_intv;
		logic [15:0] startup_hold;

		logic        deb_state [MAX_CH];
		logic        pend [MAX_CH];
		logic [31:0] pend_since [MAX_CH];
		logic [1:0]  rep_val [MAX_CH];
		logic [31:0] rep_at [MAX_CH];
		logic [31:0] last_sample;

		report_t expected [$];
		int items, sampled, skipped, forced, checked, errors;

		function new();
			sensor_count = '0;
			invert = '0;
			per_lo = '0;
			per_hi = '0;
			debounce = DEBOUNCE_RST;
			sample_intv = SAMPLE_INTV_RST;
			startup_hold = STARTUP_HOLD_RST;
			for (int i = 0; i < MAX_CH; i++) begin
				deb_state[i] = 1'b0;
				pend[i] = 1'b0;
				pend_since[i] = '0;
				rep_val[i] = REPORT_UNKNOWN;
				rep_at[i] = '0;
			end
			last_sample = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
			case (idx)
				REG_SENSOR_COUNT: sensor_count = data[3:0];
				REG_INVERT_MASK:  invert = data[7:0];
				REG_PERIODS_LOW:  per_lo = data;
				REG_PERIODS_HIGH: per_hi = data;
				REG_DEBOUNCE:     debounce = data[15:0];
				REG_SAMPLE_INTV:  sample_intv = data[15:0];
				REG_STARTUP_HOLD: startup_hold = data[15:0];
				default: ;
			endcase
		endfunction

		function int unsigned channels_in_use();
			return (sensor_count > MAX_CH) ? MAX_CH : int'(sensor_count);
		endfunction

		// wrapping elapsed time strictly beyond the span
		function bit passed(logic [31:0] now, logic [31:0] since, logic [31:0] span);
			logic [31:0] el;
			el = now - since;
			return el > span;
		endfunction

		function void publish(bit mark_all, logic lk, logic [31:0] now);
			int unsigned n;
			logic [7:0] mask;
			logic [63:0] src;
			logic [15:0] per;
			int hits [$];
			report_t r;
			n = channels_in_use();
			for (int i = 0; i < MAX_CH; i++)
				mask[i] = deb_state[i];
			if (mark_all || !lk)
				for (int i = 0; i < n; i++)
					rep_val[i] = REPORT_UNKNOWN;
			if (!lk)
				return;
			// changed value, or active channel whose re-report period ran out
			for (int i = 0; i < n; i++) begin
				src = (i < 4) ? per_lo : per_hi;
				per = src[(i % 4) * 16 +: 16];
				if ({1'b0, deb_state[i]} != rep_val[i] || (per != 0 && deb_state[i] &&
					passed(now, rep_at[i], 32'(per) * 32'(MS_PER_SECOND)))) begin
					hits.push_back(i);
					rep_val[i] = {1'b0, deb_state[i]};
					rep_at[i] = now;
				end
			end
			foreach (hits[k]) begin
				r.ch = 3'(hits[k]);
				r.val = deb_state[hits[k]];
				r.mask = mask;
				r.lst = (k == hits.size() - 1);
				expected.push_back(r);
			end
		endfunction

		function void note_item(logic f, logic [31:0] now, logic [7:0] lv, logic lk);
			int unsigned n;
			logic act;
			items++;
			if (f == FUNC_FORCE) begin
				forced++;
				publish(1'b1, lk, now);
				return;
			end
			if (now < 32'(startup_hold) || !passed(now, last_sample, 32'(sample_intv))) begin
				skipped++;
				return;
			end
			sampled++;
			last_sample = now;
			n = channels_in_use();
			// debounce each channel in use
			for (int i = 0; i < n; i++) begin
				act = lv[i] ^ invert[i];
				if (act != deb_state[i]) begin
					if (!pend[i]) begin
						pend[i] = 1'b1;
						pend_since[i] = now;
					end else if (passed(now, pend_since[i], 32'(debounce))) begin
						deb_state[i] = act;
						pend[i] = 1'b0;
						pend_since[i] = '0;
					end
				end else begin
					pend[i] = 1'b0;
					pend_since[i] = '0;
				end
			end
			publish(1'b0, lk, now);
		endfunction

		function void check_report(logic [2:0] ch, logic val, logic [7:0] mask, logic lst);
			report_t e;
			if (expected.size() == 0) begin
				$error("report on channel %0d with none expected", ch);
				errors++;
				return;
			end
			e = expected.pop_front();
			checked++;
			if (ch !== e.ch) begin
				$error("channel: expected %0d, got %0d", e.ch, ch);
				errors++;
			end
			if (val !== e.val) begin
				$error("value: expected %0b, got %0b", e.val, val);
				errors++;
			end
			if (mask !== e.mask) begin
				$error("debounced_mask: expected %h, got %h", e.mask, mask);
				errors++;
			end
			if (lst !== e.lst) begin
				$error("last: expected %0b, got %0b", e.lst, lst);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  func = FUNC_TICK;
	logic [31:0]           now_ms = '0;
	logic [7:0]            pin_levels = '0;
	logic                  link_up = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [2:0]            channel;
	logic                  value;
	logic [7:0]            debounced_mask;
	logic                  last;
	logic                  calm = 1'b0;

	debounce_scoreboard sb = new();

	multi_channel_debounce_reporter_core i_dut (.*);

	always #10 clk = ~clk;

	// output side stalls at random unless in a calm stretch
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	// watch both handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(func, now_ms, pin_levels, link_up);
			if (out_valid && out_ready)
				sb.check_report(channel, value, debounced_mask, last);
		end
	end

	// writes every register back to back while the block is idle
	task automatic set_config(input logic [3:0] cnt, input logic [7:0] inv,
		input logic [63:0] plo, input logic [63:0] phi, input logic [15:0] deb,
		input logic [15:0] intv, input logic [15:0] hold);
		logic [63:0] regs [NUM_REGS];
		regs[REG_SENSOR_COUNT] = 64'(cnt);
		regs[REG_INVERT_MASK] = 64'(inv);
		regs[REG_PERIODS_LOW] = plo;
		regs[REG_PERIODS_HIGH] = phi;
		regs[REG_DEBOUNCE] = 64'(deb);
		regs[REG_SAMPLE_INTV] = 64'(intv);
		regs[REG_STARTUP_HOLD] = 64'(hold);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= regs[i];
			sb.write_reg(CFG_IDX_W'(i), regs[i]);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// one item, with a random gap in front of it
	task automatic send_item(input logic f, input logic [31:0] t, input logic [7:0] lv,
		input logic lk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		now_ms <= t;
		pin_levels <= lv;
		link_up <= lk;
		do @(posedge clk); while (!in_ready);
	endtask

	// drain all expected reports, then let a silent item finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// time walks forward mostly past the sample interval, levels change now and then
	task automatic random_run(input int n, input logic [31:0] t0);
		logic [31:0] t;
		logic [7:0] lv;
		logic [31:0] iv, db;
		logic [31:0] step;
		t = t0;
		lv = 8'($urandom_range(255));
		iv = 32'(sb.sample_intv);
		db = 32'(sb.debounce);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(19))
				0, 1: step = $urandom_range(iv);
				2: step = iv + 1;
				3: step = $urandom_range(3000);
				4: step = $urandom_range(100000);
				5: step = $urandom();
				default: step = iv + 1 + $urandom_range(db + iv);
			endcase
			t = t + step;
			if ($urandom_range(3) == 0) begin
				if ($urandom_range(1) == 0)
					lv = 8'($urandom_range(255));
				else
					lv = lv ^ (8'd1 << $urandom_range(7));
			end
			if ($urandom_range(99) < 8)
				send_item(FUNC_FORCE, t, lv, $urandom_range(4) != 0);
			else
				send_item(FUNC_TICK, t, lv, $urandom_range(11) != 0);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no channel in use, startup hold still running
		send_item(FUNC_TICK, 32'd0, 8'h00, 1'b1);
		send_item(FUNC_TICK, 32'd999, 8'hFF, 1'b1);
		send_item(FUNC_FORCE, 32'd500, 8'h00, 1'b1);
		wait_idle();

		// all channels, low half inverted, short periods on a few channels
		set_config(4'd8, 8'h0F, {16'd0, 16'd0, 16'd2, 16'd1}, {16'hFFFF, 16'd0, 16'd1, 16'd0},
			16'd75, 16'd50, 16'd1000);
		send_item(FUNC_TICK, 32'd1000, 8'h00, 1'b1);
		send_item(FUNC_TICK, 32'd1030, 8'h00, 1'b1);
		send_item(FUNC_TICK, 32'd1051, 8'h00, 1'b1);
		send_item(FUNC_TICK, 32'd1200, 8'h00, 1'b1);
		send_item(FUNC_TICK, 32'd1300, 8'h00, 1'b0);
		send_item(FUNC_TICK, 32'd1400, 8'h00, 1'b1);
		send_item(FUNC_FORCE, 32'd1401, 8'h00, 1'b1);
		send_item(FUNC_FORCE, 32'd1402, 8'h00, 1'b0);
		send_item(FUNC_TICK, 32'd1500, 8'hFF, 1'b1);
		send_item(FUNC_TICK, 32'd1560, 8'h00, 1'b1);
		send_item(FUNC_TICK, 32'd3500, 8'h00, 1'b1);
		wait_idle();

		// oversized count, zero timing, time wrapping past the top
		set_config(4'd15, 8'h00, 64'd0, 64'd0, 16'd0, 16'd0, 16'd0);
		send_item(FUNC_TICK, 32'hFFFF_FF00, 8'h01, 1'b1);
		send_item(FUNC_TICK, 32'hFFFF_FF00, 8'h01, 1'b1);
		send_item(FUNC_TICK, 32'hFFFF_FF01, 8'h01, 1'b1);
		send_item(FUNC_TICK, 32'h0000_0010, 8'h01, 1'b1);
		send_item(FUNC_TICK, 32'h0000_0011, 8'h80, 1'b1);
		send_item(FUNC_FORCE, 32'h0000_0011, 8'h80, 1'b1);
		wait_idle();

		// random phases over several settings
		set_config(4'd8, 8'($urandom_range(255)), {16'd3, 16'd0, 16'd2, 16'd1},
			{16'd1, 16'd2, 16'd0, 16'd1}, 16'd75, 16'd50, 16'd1000);
		random_run(100, 32'd900);
		wait_idle();

		calm <= 1'b1;
		set_config(4'd15, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 16'd0, 16'd0, 16'd0);
		random_run(80, $urandom());
		wait_idle();
		calm <= 1'b0;

		set_config(4'd3, 8'h5A, {16'd0, 16'd70, 16'd1, 16'd200}, 64'($urandom()),
			16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_run(60, 32'd0);
		wait_idle();

		set_config(4'd0, 8'h00, 64'd0, 64'd0, 16'd10, 16'd10, 16'd0);
		random_run(20, 32'd5000);
		wait_idle();

		set_config(4'($urandom_range(1, 8)), 8'($urandom_range(255)),
			{16'($urandom_range(4)), 16'($urandom_range(4)), 16'($urandom_range(4)),
			16'($urandom_range(4))},
			{16'($urandom_range(4)), 16'($urandom_range(4)), 16'($urandom_range(4)),
			16'($urandom_range(4))},
			16'($urandom_range(300)), 16'($urandom_range(200)), 16'($urandom_range(2000)));
		random_run(100, 32'd0);
		wait_idle();

		set_config(4'd5, 8'h13, {16'd1, 16'd0, 16'd1, 16'd2}, {16'd0, 16'd0, 16'd0, 16'd1},
			16'd40, 16'd20, 16'd0);
		random_run(60, 32'hFFF0_0000);
		wait_idle();

		$display("covered %0d items: %0d sampled ticks, %0d dropped ticks, %0d forced reports",
			sb.items, sb.sampled, sb.skipped, sb.forced);
		$display("checked %0d reports, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("[multi_channel_debounce_reporter_core] OK");
		else
			$display("[multi_channel_debounce_reporter_core] ERROR");
		$finish;
	end

	// overall time limit
	initial begin
		#10_000_000;
		$display("[multi_channel_debounce_reporter_core] ERROR");
		$finish;
	end

endmodule
